// File: rtl/iambic_morse_keyer_assert.svh
// assertion macros of the keyer rtl, used by imk_queue
// needs clk and arst_n in the scope where a macro is used
`ifndef IAMBIC_MORSE_KEYER_ASSERT_SVH
`define IAMBIC_MORSE_KEYER_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold in the same cycle as the trigger
`define IMK_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("imk check failed");
// condition must hold in the cycle after the trigger
`define IMK_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("imk check failed");
`else
`define IMK_ASSERT_SAME(label, trig, cond)
`define IMK_ASSERT_NEXT(label, trig, cond)
`endif
`endif

// File: rtl/imk_pkg.sv
// shared types, constants and helpers of the iambic keyer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package imk_pkg;

	// widths of fields and registers
	localparam int unsigned DIT_W = 20;
	localparam int unsigned STEP_W = 13;
	localparam int unsigned WAIT_W = 20;
	localparam int unsigned CFG_W = 20;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned POS_W = 23;
	localparam int unsigned END_W = 22;
	localparam int unsigned CODE_W = 2;
	localparam int unsigned STATE_W = 3;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// register reset values
	localparam logic [DIT_W-1:0] DIT_RESET = 20'd2880;
	localparam logic [STEP_W-1:0] STEP_RESET = 13'd64;
	localparam logic [WAIT_W-1:0] WAIT_RESET = 20'd800;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIT_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT = 2'd2;

	// item kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ENQUEUE = 1'b1;

	// element codes
	localparam logic [CODE_W-1:0] EL_DIT = 2'd0;
	localparam logic [CODE_W-1:0] EL_DAH = 2'd1;
	localparam logic [CODE_W-1:0] EL_PAUSE = 2'd2;

	// reported keyer state codes
	localparam logic [STATE_W-1:0] ST_INIT = 3'd0;
	localparam logic [STATE_W-1:0] ST_INIT_PAUSE = 3'd1;
	localparam logic [STATE_W-1:0] ST_IDLE = 3'd2;
	localparam logic [STATE_W-1:0] ST_DIT = 3'd3;
	localparam logic [STATE_W-1:0] ST_DAH = 3'd4;
	localparam logic [STATE_W-1:0] ST_DIT_PAUSE = 3'd5;
	localparam logic [STATE_W-1:0] ST_DAH_PAUSE = 3'd6;

	typedef enum logic [6:0] {
		M_INIT       = 7'b0000001,
		M_INIT_PAUSE = 7'b0000010,
		M_IDLE       = 7'b0000100,
		M_DIT        = 7'b0001000,
		M_DAH        = 7'b0010000,
		M_DIT_PAUSE  = 7'b0100000,
		M_DAH_PAUSE  = 7'b1000000
	} mode_t;

	typedef enum logic [1:0] {
		LATCH_NONE = 2'd0,
		LATCH_DIT  = 2'd1,
		LATCH_DAH  = 2'd2
	} latch_t;

	typedef struct packed {
		logic [DIT_W-1:0]  dit_length;
		logic [STEP_W-1:0] tick_step;
		logic [WAIT_W-1:0] init_wait_length;
	} cfg_t;

	typedef struct packed {
		logic              push;
		logic [CODE_W-1:0] push_code;
		logic              pop;
		logic              flush;
	} queue_req_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [CODE_W-1:0] head_code;
	} queue_stat_t;

	typedef struct packed {
		logic [STATE_W-1:0] keyer_state;
		logic               key_down;
		logic               enqueue_dropped;
	} result_t;

	// one-hot mode to the reported state code
	function automatic logic [STATE_W-1:0] state_code(input mode_t m);
		logic [STATE_W-1:0] c;
		case (m)
			M_INIT:       c = ST_INIT;
			M_INIT_PAUSE: c = ST_INIT_PAUSE;
			M_IDLE:       c = ST_IDLE;
			M_DIT:        c = ST_DIT;
			M_DAH:        c = ST_DAH;
			M_DIT_PAUSE:  c = ST_DIT_PAUSE;
			M_DAH_PAUSE:  c = ST_DAH_PAUSE;
			default:      c = ST_INIT;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/imk_queue.sv
// element queue: circular buffer with a registered head entry
// depends on imk_pkg and iambic_morse_keyer_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "iambic_morse_keyer_assert.svh"

module imk_queue #(
	parameter int unsigned QUEUE_DEPTH = imk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire imk_pkg::queue_req_t req,
	output imk_pkg::queue_stat_t    stat
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [imk_pkg::CODE_W-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [imk_pkg::CODE_W-1:0] head_data_q;

	// next pointers and fill count
	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		count_n = count_q;
		if (req.flush) begin
			head_n = '0;
			tail_n = '0;
			count_n = '0;
		end else if (req.pop) begin
			head_n = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			count_n = count_q - 1'b1;
		end else if (req.push) begin
			tail_n = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			count_n = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_n;
			tail_q <= tail_n;
			count_q <= count_n;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[tail_q] <= req.push_code;
		end
	end

	// registered read of the next head entry, bypassed on a write to it
	always_ff @(posedge clk) begin
		if (req.push && (tail_q == head_n)) begin
			head_data_q <= req.push_code;
		end else begin
			head_data_q <= mem[head_n];
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CNT_FULL);
	assign stat.head_code = head_data_q;

	// checks
	`IMK_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_FULL)
	`IMK_ASSERT_SAME(a_pop_nonempty, req.pop, count_q != '0)
	`IMK_ASSERT_SAME(a_push_not_full, req.push, count_q != CNT_FULL)
	`IMK_ASSERT_NEXT(a_flush_empties, req.flush, count_q == '0)

endmodule

`default_nettype wire

// File: rtl/imk_seq.sv
// keyer sequencer: mode, paddle latch and element timing,
// one item per cycle while go is high; depends on imk_pkg
`timescale 1ns / 1ps
`default_nettype none

module imk_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic                        op,
	input  wire logic                        dit_closed,
	input  wire logic                        dah_closed,
	input  wire logic [imk_pkg::CODE_W-1:0]  element_code,
	input  wire imk_pkg::cfg_t               cfg,
	input  wire imk_pkg::queue_stat_t        qstat,
	output imk_pkg::queue_req_t              qreq,
	output imk_pkg::result_t                 result
);

	localparam int unsigned POS_W = imk_pkg::POS_W;
	localparam int unsigned END_W = imk_pkg::END_W;

	imk_pkg::mode_t mode_q, mode_n;
	imk_pkg::latch_t latch_q, latch_n;
	logic [POS_W-1:0] pos_q, pos_n, pos_base;
	logic [END_W-1:0] end_q, end_n;

	logic [END_W-1:0] dit_len, dah_len;
	logic [END_W+1:0] end_x3;
	logic [POS_W+1:0] pos_x4;
	logic late, expired, el_valid;
	logic [POS_W:0] pos_sum;

	// element lengths and the last-quarter test
	always_comb begin
		dit_len = END_W'(cfg.dit_length);
		dah_len = dit_len + {dit_len[END_W-2:0], 1'b0};
		end_x3 = {2'b00, end_q} + {1'b0, end_q, 1'b0};
		pos_x4 = {pos_q, 2'b00};
		late = pos_x4 > {1'b0, end_x3};
		expired = pos_q > {1'b0, end_q};
		el_valid = element_code inside {imk_pkg::EL_DIT, imk_pkg::EL_DAH, imk_pkg::EL_PAUSE};
	end

	// next state for one item
	always_comb begin
		mode_n = mode_q;
		latch_n = latch_q;
		end_n = end_q;
		pos_base = pos_q;
		qreq = '0;
		result.enqueue_dropped = 1'b0;
		if (op == imk_pkg::OP_ENQUEUE) begin
			qreq.push_code = element_code;
			if (el_valid) begin
				qreq.push = !qstat.full;
				result.enqueue_dropped = qstat.full;
			end
		end else begin
			if (mode_q == imk_pkg::M_INIT) begin
				pos_base = '0;
				end_n = END_W'(cfg.init_wait_length);
				mode_n = imk_pkg::M_INIT_PAUSE;
			end else if (mode_q == imk_pkg::M_IDLE) begin
				pos_base = '0;
				if (latch_q == imk_pkg::LATCH_DIT || (latch_q == imk_pkg::LATCH_NONE
						&& dit_closed)) begin
					qreq.flush = 1'b1;
					end_n = dit_len;
					mode_n = imk_pkg::M_DIT;
				end else if (latch_q == imk_pkg::LATCH_DAH || dah_closed) begin
					qreq.flush = 1'b1;
					end_n = dah_len;
					mode_n = imk_pkg::M_DAH;
				end else if (!qstat.empty) begin
					qreq.pop = 1'b1;
					case (qstat.head_code)
						imk_pkg::EL_DIT: begin
							end_n = dit_len;
							mode_n = imk_pkg::M_DIT;
						end
						imk_pkg::EL_DAH: begin
							end_n = dah_len;
							mode_n = imk_pkg::M_DAH;
						end
						default: begin
							// a queued pause from idle runs as a dah pause
							end_n = dit_len;
							mode_n = imk_pkg::M_DAH_PAUSE;
						end
					endcase
				end
				latch_n = imk_pkg::LATCH_NONE;
			end else if (expired) begin
				pos_base = '0;
				case (mode_q)
					imk_pkg::M_DIT: begin
						end_n = dit_len;
						mode_n = imk_pkg::M_DIT_PAUSE;
					end
					imk_pkg::M_DAH: begin
						end_n = dit_len;
						mode_n = imk_pkg::M_DAH_PAUSE;
					end
					imk_pkg::M_DIT_PAUSE: begin
						if (dah_closed) begin
							latch_n = imk_pkg::LATCH_NONE;
							end_n = dah_len;
							mode_n = imk_pkg::M_DAH;
						end else begin
							mode_n = imk_pkg::M_IDLE;
						end
					end
					imk_pkg::M_DAH_PAUSE: begin
						if (dit_closed) begin
							latch_n = imk_pkg::LATCH_NONE;
							end_n = dit_len;
							mode_n = imk_pkg::M_DIT;
						end else begin
							mode_n = imk_pkg::M_IDLE;
						end
					end
					default: mode_n = imk_pkg::M_IDLE;
				endcase
			end else if (mode_q == imk_pkg::M_DIT || mode_q == imk_pkg::M_DIT_PAUSE) begin
				if (dah_closed && late) latch_n = imk_pkg::LATCH_DAH;
			end else if (mode_q == imk_pkg::M_DAH || mode_q == imk_pkg::M_DAH_PAUSE) begin
				if (dit_closed && late) latch_n = imk_pkg::LATCH_DIT;
			end
		end
		// saturating advance of the position counter on ticks
		pos_sum = {1'b0, pos_base} + (POS_W + 1)'(cfg.tick_step);
		if (op == imk_pkg::OP_ENQUEUE) begin
			pos_n = pos_q;
		end else if (pos_sum[POS_W]) begin
			pos_n = imk_pkg::POS_MAX;
		end else begin
			pos_n = pos_sum[POS_W-1:0];
		end
		if (!go) begin
			qreq = '0;
		end
		result.keyer_state = imk_pkg::state_code(mode_n);
		result.key_down = (mode_n == imk_pkg::M_DIT) || (mode_n == imk_pkg::M_DAH);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= imk_pkg::M_INIT;
			latch_q <= imk_pkg::LATCH_NONE;
			pos_q <= '0;
			end_q <= '0;
		end else if (go) begin
			mode_q <= mode_n;
			latch_q <= latch_n;
			pos_q <= pos_n;
			end_q <= end_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/iambic_morse_keyer.sv
// iambic keyer top: stream ports, config registers, input and result registers
// depends on imk_pkg, imk_seq, imk_queue
//
// usage
//   input beats (s_*): s_tuser selects a tick (0) carrying the two paddle levels
//   or an enqueue (1) carrying a dit, dah or pause code for the element queue.
//   every input beat gives exactly one result beat (m_*) with the keyer state
//   after the item, the key-down flag and the queue-full drop flag.
//   an input beat passes through the input register, then the sequencer logic
//   feeding the result register, before its result beat appears.
//   throughput is one beat per cycle while m_tready is high, as the sequencer and
//   queue update their state as each beat moves on.
//   after reset the keyer is in init with an empty queue; the first tick starts
//   the start-up wait. config writes go straight into the registers.
//   when m_tready is low the result holds and one more beat is taken into the
//   input register; then s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module iambic_morse_keyer #(
	parameter int unsigned QUEUE_DEPTH = imk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // dit_closed, dah_closed, element_code[1:0]
	input  wire logic                           s_tuser,  // op
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,  // keyer_state[2:0], key_down, enqueue_dropped
	// config write port
	input  wire logic                           cfg_we,
	input  wire logic [imk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [imk_pkg::CFG_W-1:0]      cfg_data
);

	imk_pkg::cfg_t cfg_q;
	logic s1_valid;
	logic op_s1, dit_s1, dah_s1;
	logic [imk_pkg::CODE_W-1:0] code_s1;
	logic advance;
	logic out_valid_q;
	imk_pkg::result_t result, out_q;
	imk_pkg::queue_req_t qreq;
	imk_pkg::queue_stat_t qstat;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dit_length <= imk_pkg::DIT_RESET;
			cfg_q.tick_step <= imk_pkg::STEP_RESET;
			cfg_q.init_wait_length <= imk_pkg::WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				imk_pkg::CFG_DIT_LENGTH: cfg_q.dit_length <= cfg_data[imk_pkg::DIT_W-1:0];
				imk_pkg::CFG_TICK_STEP:  cfg_q.tick_step <= cfg_data[imk_pkg::STEP_W-1:0];
				imk_pkg::CFG_INIT_WAIT:  cfg_q.init_wait_length <= cfg_data[imk_pkg::WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: item moves on when the result register is free or being taken
	assign advance = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser;
			dit_s1 <= s_tdata[0];
			dah_s1 <= s_tdata[1];
			code_s1 <= s_tdata[3:2];
		end
	end

	imk_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (advance),
		.op           (op_s1),
		.dit_closed   (dit_s1),
		.dah_closed   (dah_s1),
		.element_code (code_s1),
		.cfg          (cfg_q),
		.qstat        (qstat),
		.qreq         (qreq),
		.result       (result)
	);

	imk_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.stat   (qstat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_q.enqueue_dropped, out_q.key_down, out_q.keyer_state};

endmodule

`default_nettype wire
